>>> hw/rtl/bounded_deque_with_search_defines.svh
// Assertion macros shared by the deque block.
// No dependencies; the including module must provide clk and rst_n.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDQS_CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDQS_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bdqs_pkg.sv
// Shared types and constants for the bounded deque with search.
// No dependencies.
`timescale 1ns / 1ps

package bdqs_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned OUT_CNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_SEARCH     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] operand_value;
  } in_req_t;

  typedef struct packed {
    logic                 success;
    logic [OUT_CNT_W-1:0] entry_count;
  } out_res_t;

  typedef struct packed {
    logic load_item;
    logic apply;
    logic scan_start;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_search;
    logic count_zero;
    logic out_free;
    logic scan_end;
    logic cmp_pend;
    logic found;
  } stat_t;

endpackage

>>> hw/rtl/bdqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bdqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bdqs_ctrl.sv
// Controller state machine for the deque: sequences accept, update and search.
// Depends on bdqs_pkg.
`timescale 1ns / 1ps

module bdqs_ctrl import bdqs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_search && !stat.count_zero) begin
          state_nxt = S_SCAN;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if ((stat.scan_end || stat.found) && !stat.cmp_pend) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_EXEC: begin
        if (stat.is_search && !stat.count_zero) begin
          cmd.scan_start = 1'b1;
        end else begin
          cmd.apply = stat.out_free;
        end
      end
      S_SCAN: begin
        cmd.scan_step = !stat.scan_end && !stat.found;
      end
      S_FIN: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/bdqs_dp.sv
// Datapath for the deque: ring pointers, entry store, search compare and result register.
// Depends on bdqs_pkg and bdqs_ram.
`timescale 1ns / 1ps

module bdqs_dp import bdqs_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_data,
  input  cmd_t     cmd,
  output stat_t    stat,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[IDX_W-1:0];
  endfunction

  logic [OP_W-1:0]  op_r;
  logic [VAL_W-1:0] val_r;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r;
  logic             found_r;
  logic             cmp_pend_r;
  logic             out_valid_r;
  out_res_t         out_data_r;

  logic             ok;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  logic [VAL_W-1:0] rd_data;
  logic             full;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign raddr = wrap_add(front_r, idx_r);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    ok        = 1'b0;
    we        = 1'b0;
    waddr     = front_r;
    case (op_r)
      OP_PUSH_FRONT: begin
        if (!full) begin
          front_nxt = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - IDX_W'(1);
          waddr     = front_nxt;
          we        = cmd.apply;
          count_nxt = count_r + CNT_W'(1);
          ok        = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (!full) begin
          waddr     = wrap_add(front_r, count_r);
          we        = cmd.apply;
          count_nxt = count_r + CNT_W'(1);
          ok        = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (count_r != '0) begin
          front_nxt = wrap_add(front_r, CNT_W'(1));
          count_nxt = count_r - CNT_W'(1);
          ok        = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (count_r != '0) begin
          count_nxt = count_r - CNT_W'(1);
          ok        = 1'b1;
        end
      end
      OP_CLEAR: begin
        front_nxt = '0;
        count_nxt = '0;
        ok        = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  bdqs_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(val_r),
    .raddr(raddr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      cmp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.apply) begin
        front_r <= front_nxt;
        count_r <= count_nxt;
      end
      cmp_pend_r <= cmd.scan_step;
      if (cmd.scan_start) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.scan_step) idx_r <= idx_r + CNT_W'(1);
        if (cmp_pend_r && (rd_data == val_r)) found_r <= 1'b1;
      end
      if (cmd.apply || cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= in_data.op;
      val_r <= $unsigned(in_data.operand_value);
    end
    if (cmd.apply) begin
      out_data_r.success     <= ok;
      out_data_r.entry_count <= OUT_CNT_W'(count_nxt);
    end else if (cmd.finish) begin
      out_data_r.success     <= found_r;
      out_data_r.entry_count <= OUT_CNT_W'(count_r);
    end
  end

  assign stat.is_search  = (op_r == OP_SEARCH);
  assign stat.count_zero = (count_r == '0);
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.scan_end   = (idx_r == count_r);
  assign stat.cmp_pend   = cmp_pend_r;
  assign stat.found      = found_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/bounded_deque_with_search.sv
// Top level of the bounded deque with search: controller plus datapath.
// Depends on bdqs_pkg, bdqs_ctrl, bdqs_dp and the assertion macro header.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+--------------------------------
//   in      | in_valid, in_ready  | in_data  (op, operand_value)
//   out     | out_valid, out_ready| out_data (success, entry_count)
//
// Push, pop, clear, unused codes and search on an empty store go from the accepting edge
// to the execute state, which writes the result register once the output is free.
// A search reads one held entry per cycle from the single read port of the entry store;
// it stops at the end of the held entries, or earlier when a match is found.
// One request is in work at a time; the next is accepted while the last result waits.
// A stalled result holds in the output register; rst_n clears pointers and count at the
// next clock edge.
`timescale 1ns / 1ps
`include "bounded_deque_with_search_defines.svh"

module bounded_deque_with_search import bdqs_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  bdqs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  bdqs_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  `BDQS_CHK_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "request accepted while busy")
  `BDQS_CHK_SAME(a_no_overwrite, cmd.apply || cmd.finish, stat.out_free, "result overwritten")
  `BDQS_CHK_SAME(a_scan_bound, cmd.scan_step, !stat.scan_end, "search read past held entries")

endmodule
